FILE: hdl/rbca_pkg.sv
// Shared types, sizes and helpers for the result bus completion arbiter.
// No dependencies; the datapath, controller and top level import this package.
`default_nettype none
package rbca_pkg;

  localparam int MAX_BUSES   = 8;
  localparam int QUEUE_DEPTH = 32;
  localparam int BATCH_DEPTH = 16;
  localparam int QW          = $clog2(QUEUE_DEPTH);
  localparam int BW          = $clog2(BATCH_DEPTH);

  localparam logic [3:0] RB_RESET = 4'd2;
  localparam logic [3:0] RB_MAX   = 4'(MAX_BUSES);

  typedef struct packed {
    logic [31:0]       tag;
    logic signed [7:0] wake;
    logic [1:0]        unit;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic in_ready;
    logic check;
    logic insert;
    logic app_step;
    logic set_n;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic in_is_tick;
    logic app_done;
    logic slot_free;
    logic grant_last;
  } status_t;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // magnitude of the unit code, unknown units map to 3
  function automatic logic [1:0] unit_of(input logic [2:0] code);
    logic [1:0] u;
    case (code)
      3'd0:    u = 2'd0;
      3'd1:    u = 2'd1;
      3'd2:    u = 2'd2;
      3'd6:    u = 2'd2;
      3'd7:    u = 2'd1;
      default: u = 2'd3;
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/rbca_in_if.sv
// Input channel: completion reports and cycle ticks.
// Depends on nothing but the valid/ready convention.
`default_nettype none
interface rbca_in_if;
  logic              valid;
  logic              ready;
  logic              command;
  logic [31:0]       instruction_tag;
  logic signed [7:0] dest_register;
  logic signed [2:0] unit_code;
  logic [31:0]       cycle_number;

  modport source (output valid, command, instruction_tag, dest_register, unit_code,
                  cycle_number, input ready);
  modport sink (input valid, command, instruction_tag, dest_register, unit_code,
                cycle_number, output ready);
endinterface
`default_nettype wire

FILE: hdl/rbca_out_if.sv
// Result channel: one word per grant, or one empty word per tick.
// Depends on nothing but the valid/ready convention.
`default_nettype none
interface rbca_out_if;
  logic              valid;
  logic              ready;
  logic              granted;
  logic [31:0]       grant_tag;
  logic signed [7:0] wake_register;
  logic [1:0]        unit_index;
  logic [31:0]       retire_cycle;
  logic [3:0]        grants_this_cycle;
  logic              overflow_seen;
  logic              last;

  modport source (output valid, granted, grant_tag, wake_register, unit_index,
                  retire_cycle, grants_this_cycle, overflow_seen, last, input ready);
  modport sink (input valid, granted, grant_tag, wake_register, unit_index,
                retire_cycle, grants_this_cycle, overflow_seen, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/rbca_dp.sv
// Datapath: sorted batch, circular waiting queue, tag compare, output register.
// Depends on rbca_pkg, rbca_in_if and rbca_out_if.
`default_nettype none
module rbca_dp
  import rbca_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic [3:0] result_buses,
  input  wire cmd_t    cmd,
  output status_t      sts,
  rbca_in_if.sink      in_ch,
  rbca_out_if.source   out_ch
);

  entry_t q_r [QUEUE_DEPTH];
  entry_t b_r [BATCH_DEPTH];

  logic [QW-1:0] head_r;
  logic [QW:0]   wc_r;
  logic [BW:0]   bc_r;
  logic [BW:0]   a_r;
  logic [BW:0]   pos_r;
  logic [3:0]    n_r;
  logic [3:0]    k_r;
  logic          hit_r;
  logic          ovf_r;

  entry_t        new_r;
  logic [31:0]   cyc_r;

  logic          ov_valid_r;
  logic          ov_granted_r;
  entry_t        ov_e_r;
  logic [31:0]   ov_cyc_r;
  logic [3:0]    ov_n_r;
  logic          ov_ovf_r;
  logic          ov_last_r;

  logic [QUEUE_DEPTH-1:0] qhit;
  logic [BATCH_DEPTH-1:0] bhit;
  logic [BATCH_DEPTH-1:0] bless;
  logic [3:0]    lim;
  logic [3:0]    n_comb;
  logic          full;
  logic [QW-1:0] tail;
  logic [QW-1:0] qoff;

  assign in_ch.ready = cmd.in_ready;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      qoff    = QW'(i) - head_r;
      qhit[i] = ({1'b0, qoff} < wc_r) && (q_r[i].tag == new_r.tag);
    end
    for (int j = 0; j < BATCH_DEPTH; j++) begin
      bhit[j]  = ((BW+1)'(j) < bc_r) && (b_r[j].tag == new_r.tag);
      bless[j] = ((BW+1)'(j) < bc_r) && (b_r[j].tag < new_r.tag);
    end
  end

  assign full   = (bc_r == (BW+1)'(BATCH_DEPTH)) ||
                  ((QW+1)'(wc_r + (QW+1)'(bc_r)) >= (QW+1)'(QUEUE_DEPTH));
  assign tail   = head_r + wc_r[QW-1:0];
  assign lim    = (result_buses > RB_MAX) ? RB_MAX : result_buses;
  assign n_comb = (wc_r < (QW+1)'(lim)) ? wc_r[3:0] : lim;

  assign sts.in_valid   = in_ch.valid;
  assign sts.in_is_tick = (in_ch.command == CMD_TICK);
  assign sts.app_done   = (a_r == bc_r);
  assign sts.slot_free  = !ov_valid_r || out_ch.ready;
  assign sts.grant_last = (n_r == 4'd0) || (k_r + 4'd1 == n_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      wc_r       <= '0;
      bc_r       <= '0;
      a_r        <= '0;
      n_r        <= '0;
      k_r        <= '0;
      ovf_r      <= 1'b0;
      ov_valid_r <= 1'b0;
    end else begin
      if (cmd.insert && !hit_r) begin
        if (full) ovf_r <= 1'b1;
        else      bc_r  <= bc_r + 1'b1;
      end
      if (cmd.app_step) begin
        a_r  <= a_r + 1'b1;
        wc_r <= wc_r + 1'b1;
      end
      if (cmd.set_n) begin
        n_r  <= n_comb;
        bc_r <= '0;
        a_r  <= '0;
        k_r  <= '0;
      end
      if (cmd.emit) begin
        ov_valid_r <= 1'b1;
        if (n_r != 4'd0) begin
          head_r <= head_r + 1'b1;
          wc_r   <= wc_r - 1'b1;
          k_r    <= k_r + 1'b1;
        end
      end else if (out_ch.ready) begin
        ov_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && cmd.in_ready) begin
      new_r.tag   <= in_ch.instruction_tag;
      new_r.wake  <= in_ch.dest_register[7] ? 8'shFF : in_ch.dest_register;
      new_r.unit  <= unit_of(in_ch.unit_code);
      cyc_r       <= in_ch.cycle_number;
    end
    if (cmd.check) begin
      hit_r <= (|qhit) || (|bhit);
      pos_r <= (BW+1)'($countones(bless));
    end
    // keep the batch sorted by opening a slot at the insert position
    if (cmd.insert && !hit_r && !full) begin
      for (int j = 0; j < BATCH_DEPTH; j++) begin
        if ((BW+1)'(j) > pos_r && (BW+1)'(j) <= bc_r)
          b_r[j] <= b_r[(j == 0) ? 0 : j - 1];
        else if ((BW+1)'(j) == pos_r)
          b_r[j] <= new_r;
      end
    end
    if (cmd.app_step) q_r[tail] <= b_r[a_r[BW-1:0]];
    if (cmd.emit) begin
      ov_granted_r <= (n_r != 4'd0);
      ov_cyc_r     <= (n_r != 4'd0) ? cyc_r : 32'd0;
      ov_n_r       <= n_r;
      ov_ovf_r     <= ovf_r;
      ov_last_r    <= sts.grant_last;
      if (n_r != 4'd0) ov_e_r <= q_r[head_r];
      else             ov_e_r <= '{tag: 32'd0, wake: 8'shFF, unit: 2'd0};
    end
  end

  assign out_ch.valid             = ov_valid_r;
  assign out_ch.granted           = ov_granted_r;
  assign out_ch.grant_tag         = ov_e_r.tag;
  assign out_ch.wake_register     = ov_e_r.wake;
  assign out_ch.unit_index        = ov_e_r.unit;
  assign out_ch.retire_cycle      = ov_cyc_r;
  assign out_ch.grants_this_cycle = ov_n_r;
  assign out_ch.overflow_seen     = ov_ovf_r;
  assign out_ch.last              = ov_last_r;

endmodule
`default_nettype wire

FILE: hdl/rbca_ctrl.sv
// Controller: sequences report checks, batch appends and grant emission.
// Depends on rbca_pkg for the command and status structs.
`default_nettype none
module rbca_ctrl
  import rbca_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire status_t sts,
  output cmd_t         cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_INSERT = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_GRANT  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) state_nxt = sts.in_is_tick ? S_APPEND : S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_APPEND: begin
        if (sts.app_done) begin
          cmd.set_n = 1'b1;
          state_nxt = S_GRANT;
        end else begin
          cmd.app_step = 1'b1;
        end
      end
      S_GRANT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.grant_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/result_bus_completion_arbiter.sv
// Result bus completion arbiter: top level with the APB register and the two halves.
// Report: accepted in idle, then tag compare and sorted insert; next word taken after that.
// Tick: the batch is copied behind the waiting entries, then one grant word per cycle
// while the output is ready (at least one word). Depends on rbca_pkg, rbca_in_if,
// rbca_out_if.
// Reset (rst_n low, synchronous): queue and batch empty, overflow clear, result_buses 2.
`default_nettype none
module result_bus_completion_arbiter
  import rbca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  rbca_in_if.sink          in_chan,
  rbca_out_if.source       out_chan,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cmd_t       cmd;
  status_t    sts;
  logic [3:0] rb_r;

  // Single register; the address bits are not decoded, so it answers at every address.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {28'd0, rb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r <= RB_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      rb_r <= cfg_pwdata[3:0];
    end
  end

  logic unused_addr;
  assign unused_addr = ^cfg_paddr;

  // Controller issues one command group per cycle; the datapath reports back.
  rbca_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Datapath holds the batch in tag order at all times, so a tick only
  // has to copy it behind the waiting entries, one entry a cycle.
  rbca_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_buses (rb_r),
    .cmd          (cmd),
    .sts          (sts),
    .in_ch        (in_chan),
    .out_ch       (out_chan)
  );

endmodule
`default_nettype wire
